// File: design/ca3_pkg.sv
// Shared types, constants and the cell update rule of the 3D cellular automaton step block.
`default_nettype none

package ca3_pkg;

    localparam int GRID_SIZE_DEF = 16;

    localparam int STATE_W    = 2;
    localparam int DWELL_W    = 8;
    localparam int CHG_W      = 13;
    localparam int TH_W       = 7;
    localparam int SUM_W      = 7;
    localparam int PSUM_W     = 5;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;

    localparam logic [CHG_W-1:0] CHG_MAX = '1;

    localparam logic NBR_FACES = 1'b0;

    localparam logic [STATE_W-1:0] CS_INACTIVE     = 2'd0;
    localparam logic [STATE_W-1:0] CS_ACTIVE       = 2'd1;
    localparam logic [STATE_W-1:0] CS_ACTIVATING   = 2'd2;
    localparam logic [STATE_W-1:0] CS_DEACTIVATING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_TH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEACT_TH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS    = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_GEN   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        logic               moore;
        logic [TH_W-1:0]    act_th;
        logic [TH_W-1:0]    deact_th;
        logic [DWELL_W-1:0] dwell_gen;
        logic               trans_en;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        moore:     1'b0,
        act_th:    7'd4,
        deact_th:  7'd6,
        dwell_gen: 8'd0,
        trans_en:  1'b0
    };

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [DWELL_W-1:0] dwell;
    } t_cell;

    function automatic t_cell ca3_next(t_cell cur, logic [SUM_W-1:0] sum, t_cfg cfg);
        t_cell nxt;
        nxt = cur;
        if (cfg.trans_en && (cur.state == CS_ACTIVATING || cur.state == CS_DEACTIVATING)) begin
            if (cur.dwell == cfg.dwell_gen) begin
                nxt.state = (cur.state == CS_ACTIVATING) ? CS_ACTIVE : CS_INACTIVE;
                nxt.dwell = '0;
            end else begin
                nxt.dwell = cur.dwell + DWELL_W'(1);
            end
        end else if (cur.state == CS_ACTIVE) begin
            if (sum >= cfg.deact_th) begin
                nxt.state = cfg.trans_en ? CS_DEACTIVATING : CS_INACTIVE;
            end
        end else if (cur.state == CS_INACTIVE) begin
            if (sum >= cfg.act_th) begin
                nxt.state = cfg.trans_en ? CS_ACTIVATING : CS_ACTIVE;
            end
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: design/ca3_cell.sv
// One stage of the neighbourhood window chain: holds one cell state code.
`default_nettype none

module ca3_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_shift,
    input  wire logic [ca3_pkg::STATE_W-1:0]  i_d,
    output logic      [ca3_pkg::STATE_W-1:0]  o_q
);
    import ca3_pkg::*;

    logic [STATE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: design/ca3_window.sv
// Chain of cells spanning three grid planes, with masked neighbour sums of the centre cell.
`default_nettype none

module ca3_window #(
    parameter int GRID_SIZE = ca3_pkg::GRID_SIZE_DEF,
    localparam int CW = $clog2(GRID_SIZE)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_shift,
    input  wire logic [ca3_pkg::STATE_W-1:0] i_d,
    input  wire logic [CW-1:0]               i_cx,
    input  wire logic [CW-1:0]               i_cy,
    input  wire logic [CW-1:0]               i_cz,
    input  wire ca3_pkg::t_cfg               i_cfg,
    output logic      [ca3_pkg::SUM_W-1:0]   o_sum,
    output logic      [ca3_pkg::STATE_W-1:0] o_centre
);
    import ca3_pkg::*;

    localparam int G2    = GRID_SIZE * GRID_SIZE;
    localparam int LAG   = G2 + GRID_SIZE + 1;
    localparam int DEPTH = 2 * LAG + 1;

    logic [STATE_W-1:0] w_q [DEPTH];
    logic [2:0]         w_okx, w_oky, w_okz;
    logic [PSUM_W-1:0]  w_ps [3];
    logic [PSUM_W-1:0]  r_ps [3];
    logic [STATE_W-1:0] r_c;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            ca3_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (i_d),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            ca3_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (w_q[g-1]),
                .o_q     (w_q[g])
            );
        end
    end

    assign w_okx = {i_cx != CW'(GRID_SIZE - 1), 1'b1, i_cx != '0};
    assign w_oky = {i_cy != CW'(GRID_SIZE - 1), 1'b1, i_cy != '0};
    assign w_okz = {i_cz != CW'(GRID_SIZE - 1), 1'b1, i_cz != '0};

    always_comb begin
        int hops;
        int off;
        for (int ix = 0; ix < 3; ix++) begin
            w_ps[ix] = '0;
            for (int iy = 0; iy < 3; iy++) begin
                for (int iz = 0; iz < 3; iz++) begin
                    hops = int'(ix != 1) + int'(iy != 1) + int'(iz != 1);
                    off  = (ix - 1) * G2 + (iy - 1) * GRID_SIZE + (iz - 1);
                    if (hops != 0 && (i_cfg.moore != NBR_FACES || hops == 1) &&
                        w_okx[ix] && w_oky[iy] && w_okz[iz]) begin
                        w_ps[ix] = w_ps[ix] + PSUM_W'(w_q[LAG - off]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ps <= w_ps;
        r_c  <= w_q[LAG];
    end

    assign o_sum    = SUM_W'(r_ps[0]) + SUM_W'(r_ps[1]) + SUM_W'(r_ps[2]);
    assign o_centre = r_c;

endmodule

`default_nettype wire

// File: design/cellular_automaton_3d_step_top.sv
// Top level of the 3D cellular automaton step block: grid memories, sweep control, ports.
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | cmd, pos_x, pos_y, pos_z, load_state
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | cell_state, dwell_count, changed_cells
//  cfg       | in        | i_cfg_we                     | i_cfg_idx, i_cfg_wdata
//
//  A generation streams one cell a cycle through the single read port of the state memory
//  into the window chain, which is filled before the first update is written back.
//  After reset the grid is swept clear with s_axis_tready low.
//  s_axis_tready is high only while no item is in work; a result waits in the output register
//  and the next item may be taken meanwhile.
`default_nettype none

module cellular_automaton_3d_step_top #(
    parameter int GRID_SIZE = ca3_pkg::GRID_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[1:0], pos_x[5:2], pos_y[9:6], pos_z[13:10], load_state[15:14]
    input  wire logic [ca3_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // cell_state[1:0], dwell_count[9:2], changed_cells[22:10], zero[23]
    output logic      [ca3_pkg::OUT_W-1:0]      m_axis_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [ca3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ca3_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ca3_pkg::*;

    localparam int G2      = GRID_SIZE * GRID_SIZE;
    localparam int CELLS   = G2 * GRID_SIZE;
    localparam int LAG     = G2 + GRID_SIZE + 1;
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = $clog2(GRID_SIZE);
    localparam int GEN_END = CELLS + LAG + 2;
    localparam int TW      = $clog2(GEN_END + 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_GEN  = 6'b000100,
        S_RD   = 6'b001000,
        S_RDW  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [TW-1:0]      r_t;
    logic               r_boot;
    logic               r_ov;
    logic               r_mv;
    logic               r_bv;
    t_cfg               r_cfg;

    logic [AW-1:0]      r_idx;
    logic               r_ok;
    logic [AW-1:0]      r_bi;
    logic [CHG_W-1:0]   r_cnt;
    logic [CW-1:0]      r_cx, r_cy, r_cz;
    t_cell              r_pend;
    t_cell              r_out;
    logic [CHG_W-1:0]   r_ochg;

    logic [STATE_W-1:0] r_mem_state [CELLS];
    logic [DWELL_W-1:0] r_mem_dwell [CELLS];
    logic [STATE_W-1:0] r_sq;
    logic [DWELL_W-1:0] r_dq;

    t_cmd               w_cmd;
    logic [POS_W-1:0]   w_px, w_py, w_pz;
    logic [STATE_W-1:0] w_ld;
    logic               w_ok;
    logic [AW-1:0]      w_idx;
    logic               w_acc;
    logic               w_free;
    logic               w_cv;
    logic [TW-1:0]      w_cdiff;
    logic [AW-1:0]      w_ci;
    logic [AW-1:0]      w_sra, w_dra, w_wa;
    logic               w_we;
    t_cell              w_wd;
    logic [SUM_W-1:0]   w_sum;
    logic [STATE_W-1:0] w_ctr;
    t_cell              w_upd;
    logic               w_chg;

    assign w_cmd = t_cmd'(s_axis_tdata[1:0]);
    assign w_px  = s_axis_tdata[5:2];
    assign w_py  = s_axis_tdata[9:6];
    assign w_pz  = s_axis_tdata[13:10];
    assign w_ld  = s_axis_tdata[15:14];

    assign w_ok  = (32'(w_px) < GRID_SIZE) && (32'(w_py) < GRID_SIZE) && (32'(w_pz) < GRID_SIZE);
    assign w_idx = AW'(32'(w_px) * G2 + 32'(w_py) * GRID_SIZE + 32'(w_pz));

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_free        = !r_ov || m_axis_tready;

    assign w_cv    = (r_state == S_GEN) && (r_t >= TW'(LAG + 2)) && (r_t < TW'(CELLS + LAG + 2));
    assign w_cdiff = r_t - TW'(LAG + 2);
    assign w_ci    = w_cdiff[AW-1:0];

    ca3_window #(
        .GRID_SIZE (GRID_SIZE)
    ) u_window (
        .i_clk    (i_clk),
        .i_shift  (r_state == S_GEN),
        .i_d      (r_mv ? r_sq : CS_INACTIVE),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_cz     (r_cz),
        .i_cfg    (r_cfg),
        .o_sum    (w_sum),
        .o_centre (w_ctr)
    );

    assign w_upd = ca3_next(t_cell'{state: w_ctr, dwell: r_dq}, w_sum, r_cfg);
    assign w_chg = r_bv && (w_upd.state != w_ctr);

    always_comb begin
        w_sra = w_idx;
        w_dra = w_idx;
        w_we  = 1'b0;
        w_wa  = w_idx;
        w_wd  = '{state: w_ld, dwell: '0};
        unique case (r_state) inside
            S_CLR: begin
                w_we = 1'b1;
                w_wa = r_t[AW-1:0];
                w_wd = '0;
            end
            S_IDLE: begin
                w_we = w_acc && (w_cmd == CMD_LOAD) && w_ok;
            end
            S_GEN: begin
                w_sra = r_t[AW-1:0];
                w_dra = w_ci;
                w_we  = r_bv;
                w_wa  = r_bi;
                w_wd  = w_upd;
            end
            S_RD, S_RDW, S_FIN: begin
                w_sra = r_idx;
                w_dra = r_idx;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_state[w_wa] <= w_wd.state;
        end
        r_sq <= r_mem_state[w_sra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_dwell[w_wa] <= w_wd.dwell;
        end
        r_dq <= r_mem_dwell[w_dra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_t     <= '0;
            r_boot  <= 1'b1;
            r_ov    <= 1'b0;
            r_mv    <= 1'b0;
            r_bv    <= 1'b0;
            r_cfg   <= CFG_RESET;
        end else begin
            r_mv <= (r_state == S_GEN) && (r_t < TW'(CELLS));
            r_bv <= w_cv;

            if (r_state == S_FIN && w_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE:     r_cfg.moore     <= i_cfg_wdata[0];
                    REG_ACT_TH:   r_cfg.act_th    <= i_cfg_wdata[TH_W-1:0];
                    REG_DEACT_TH: r_cfg.deact_th  <= i_cfg_wdata[TH_W-1:0];
                    REG_DWELL:    r_cfg.dwell_gen <= i_cfg_wdata;
                    REG_TRANS:    r_cfg.trans_en  <= i_cfg_wdata[0];
                    default:      r_cfg           <= r_cfg;
                endcase
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_t == TW'(CELLS - 1)) begin
                        r_t     <= '0;
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_FIN;
                    end else begin
                        r_t <= r_t + TW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_t <= '0;
                        unique case (w_cmd)
                            CMD_LOAD:  r_state <= S_FIN;
                            CMD_READ:  r_state <= S_RDW;
                            CMD_GEN:   r_state <= S_GEN;
                            CMD_CLEAR: r_state <= S_CLR;
                            default:   r_state <= S_FIN;
                        endcase
                    end
                end
                S_GEN: begin
                    r_t <= r_t + TW'(1);
                    if (r_t == TW'(GEN_END)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_bi <= w_ci;
        if (w_acc) begin
            r_idx  <= w_idx;
            r_ok   <= w_ok;
            r_cnt  <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_pend <= (w_cmd == CMD_LOAD && w_ok) ? t_cell'{state: w_ld, dwell: '0} : '0;
        end else begin
            if (w_cv) begin
                if (r_cz == CW'(GRID_SIZE - 1)) begin
                    r_cz <= '0;
                    if (r_cy == CW'(GRID_SIZE - 1)) begin
                        r_cy <= '0;
                        r_cx <= r_cx + CW'(1);
                    end else begin
                        r_cy <= r_cy + CW'(1);
                    end
                end else begin
                    r_cz <= r_cz + CW'(1);
                end
            end
            if (w_chg && r_cnt != CHG_MAX) begin
                r_cnt <= r_cnt + CHG_W'(1);
            end
            if (r_state == S_RDW) begin
                r_pend <= r_ok ? t_cell'{state: r_sq, dwell: r_dq} : '0;
            end
        end
        if (r_state == S_FIN && w_free) begin
            r_out  <= r_pend;
            r_ochg <= r_cnt;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_ochg, r_out.dwell, r_out.state};

endmodule

`default_nettype wire

// File: design/ca3_check.sv
// Port checker for the 3D cellular automaton step block, bound to the top level.
`default_nettype none

module ca3_check (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [ca3_pkg::OUT_W-1:0] m_axis_tdata
);
    import ca3_pkg::*;

    logic [STATE_W-1:0] w_st;
    logic [DWELL_W-1:0] w_dw;

    assign w_st = m_axis_tdata[STATE_W-1:0];
    assign w_dw = m_axis_tdata[STATE_W+DWELL_W-1:STATE_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while first in work");

    a_settled_dwell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_st == CS_INACTIVE || w_st == CS_ACTIVE) |-> w_dw == '0)
        else $error("settled cell reports a running dwell counter");

endmodule

bind cellular_automaton_3d_step_top ca3_check u_ca3_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
